/* hw/rtl/emv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emv_pkg
// Shared types and constants for the multi-turn encoder velocity block.
// ----------------------------------------------------------------------------
package emv_pkg;

	// fixed field widths
	localparam int TURN_W  = 32;
	localparam int POS_W   = 44;
	localparam int VEL_W   = 48;
	localparam int THR_W   = 12;
	localparam int RATE_W  = 26;
	localparam int MINDT_W = 24;
	localparam int GAIN_W  = 17;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd3;

	localparam logic [THR_W-1:0]   THRESHOLD_RST = 12'd3276;
	localparam logic [RATE_W-1:0]  RATE_RST      = 26'd9000000;
	localparam logic [MINDT_W-1:0] MIN_DT_RST    = 24'd9;
	localparam logic [GAIN_W-1:0]  GAIN_RST      = 17'd13107;

	// unity filter gain in Q16
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TURN,
		ST_DIFF,
		ST_MUL,
		ST_DIV,
		ST_FDEL,
		ST_FLO,
		ST_FHI,
		ST_FSUM,
		ST_FIN
	} emv_state_t;

	typedef struct packed {
		logic load;
		logic turn;
		logic diff;
		logic mul;
		logic div_step;
		logic fdel;
		logic flo;
		logic fhi;
		logic fsum;
		logic fin;
	} emv_cmd_t;

	typedef struct packed {
		logic div_last;
	} emv_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/emv_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emv_if
// Valid/ready channels for angle samples and for position/velocity results.
// ----------------------------------------------------------------------------
interface emv_in_if #(
	parameter int ANGLE_BITS = 12,
	parameter int TIMER_BITS = 24
);
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] raw_angle;
	logic [TIMER_BITS-1:0] timer_value;

	modport source (output valid, output raw_angle, output timer_value, input ready);
	modport sink   (input valid, input raw_angle, input timer_value, output ready);
endinterface

interface emv_out_if;
	import emv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TURN_W-1:0] turn_count;
	logic signed [POS_W-1:0]  position;
	logic signed [VEL_W-1:0]  velocity_filtered;

	modport source (output valid, output turn_count, output position,
		output velocity_filtered, input ready);
	modport sink   (input valid, input turn_count, input position,
		input velocity_filtered, output ready);
endinterface
`default_nettype wire

/* hw/rtl/emv_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emv_ctrl
// Sequencer for one sample: unwrap, difference, multiply, divide, filter.
// ----------------------------------------------------------------------------
module emv_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire emv_pkg::emv_sts_t sts,
	output emv_pkg::emv_cmd_t      cmd
);
	import emv_pkg::*;

	emv_state_t state_q;
	emv_state_t state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_TURN;
			ST_TURN: state_nxt = ST_DIFF;
			ST_DIFF: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_DIV;
			ST_DIV:  if (sts.div_last) state_nxt = ST_FDEL;
			ST_FDEL: state_nxt = ST_FLO;
			ST_FLO:  state_nxt = ST_FHI;
			ST_FHI:  state_nxt = ST_FSUM;
			ST_FSUM: state_nxt = ST_FIN;
			ST_FIN:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_TURN: cmd.turn     = 1'b1;
			ST_DIFF: cmd.diff     = 1'b1;
			ST_MUL:  cmd.mul      = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FDEL: cmd.fdel     = 1'b1;
			ST_FLO:  cmd.flo      = 1'b1;
			ST_FHI:  cmd.fhi      = 1'b1;
			ST_FSUM: cmd.fsum     = 1'b1;
			ST_FIN:  cmd.fin      = out_free;
			default: cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a new result wins over the transfer of the old one
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/emv_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emv_dp
// Turn counter, position difference, restoring divider and low-pass filter.
// ----------------------------------------------------------------------------
module emv_dp #(
	parameter int ANGLE_BITS = 12,
	parameter int TIMER_BITS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire emv_pkg::emv_cmd_t                 cmd,
	output emv_pkg::emv_sts_t                      sts,
	input  wire logic [ANGLE_BITS-1:0]             raw_angle,
	input  wire logic [TIMER_BITS-1:0]             timer_value,
	input  wire logic [emv_pkg::THR_W-1:0]         cfg_threshold,
	input  wire logic [emv_pkg::RATE_W-1:0]        cfg_rate,
	input  wire logic [emv_pkg::MINDT_W-1:0]       cfg_min_dt,
	input  wire logic [emv_pkg::GAIN_W-1:0]        cfg_gain,
	output logic signed [emv_pkg::TURN_W-1:0]      turn_count,
	output logic signed [emv_pkg::POS_W-1:0]       position,
	output logic signed [emv_pkg::VEL_W-1:0]       velocity_filtered
);
	import emv_pkg::*;

	localparam int CMP_W  = (ANGLE_BITS > THR_W) ? ANGLE_BITS : THR_W;
	localparam int PF_W   = TURN_W + ANGLE_BITS;
	localparam int D_W    = POS_W + 1;
	localparam int DT_W   = (TIMER_BITS + 1 > MINDT_W) ? TIMER_BITS + 1 : MINDT_W;
	localparam int PROD_W = ANGLE_BITS + RATE_W;
	localparam int NUM_W  = PROD_W + 8;
	localparam int R_W    = NUM_W + 1;
	localparam int DL_W   = ((R_W > VEL_W) ? R_W : VEL_W) + 1;
	localparam int LO_W   = 24;
	localparam int HI_W   = DL_W - LO_W;
	localparam int PLO_W  = GAIN_W + LO_W;
	localparam int PHI_W  = GAIN_W + 1 + HI_W;
	localparam int S_W    = DL_W + GAIN_W + 2;
	localparam int CNT_W  = $clog2(NUM_W);

	localparam logic signed [D_W-1:0]      HALF_D  = D_W'(64'd1 << (ANGLE_BITS - 1));
	localparam logic signed [D_W-1:0]      NHALF_D = -HALF_D;
	localparam logic [ANGLE_BITS-1:0]      HALF_M  = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));
	localparam logic [TIMER_BITS-1:0]      TMASK   = {TIMER_BITS{1'b1}};
	localparam logic [CNT_W-1:0]           CNT_LAST = CNT_W'(NUM_W - 1);
	localparam logic signed [S_W-1:0]      ROUND_S = S_W'(64'sd32768);
	localparam logic signed [S_W-1:0]      VMAX_S  = S_W'(VEL_MAX);
	localparam logic signed [S_W-1:0]      VMIN_S  = S_W'(VEL_MIN);

	// model state
	logic [ANGLE_BITS-1:0]      last_raw_q;
	logic signed [TURN_W-1:0]   turns_q;
	logic [TIMER_BITS-1:0]      last_timer_q;
	logic signed [POS_W-1:0]    last_pos_q;
	logic signed [VEL_W-1:0]    vel_q;

	// per-sample working registers
	logic [ANGLE_BITS-1:0]      raw_q;
	logic [TIMER_BITS-1:0]      tim_q;
	logic signed [POS_W-1:0]    pos_q;
	logic [ANGLE_BITS-1:0]      mag_q;
	logic                       neg_q;
	logic [DT_W-1:0]            dt_q;
	logic [NUM_W-1:0]           num_q;
	logic [DT_W-1:0]            rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [DL_W-1:0]     delta_q;
	logic [PLO_W-1:0]           plo_q;
	logic signed [PHI_W-1:0]    phi_q;
	logic signed [S_W-1:0]      acc_q;
	logic signed [VEL_W-1:0]    vnew_q;

	// turn stage
	logic signed [ANGLE_BITS:0] jump;
	logic [ANGLE_BITS:0]        njump;
	logic [ANGLE_BITS-1:0]      ajump;
	logic                       big_jump;
	logic signed [TURN_W-1:0]   turns_nxt;

	assign jump     = $signed({1'b0, raw_q}) - $signed({1'b0, last_raw_q});
	assign njump    = -jump;
	assign ajump    = jump[ANGLE_BITS] ? njump[ANGLE_BITS-1:0] : jump[ANGLE_BITS-1:0];
	assign big_jump = CMP_W'(ajump) > CMP_W'(cfg_threshold);

	always_comb begin
		turns_nxt = turns_q;
		if (big_jump) begin
			// positive jump means the angle wrapped backwards
			turns_nxt = jump[ANGLE_BITS] ? turns_q + 32'sd1 : turns_q - 32'sd1;
		end
	end

	// difference stage
	logic signed [PF_W-1:0]       pf;
	logic signed [POS_W-1:0]      pos_c;
	logic signed [D_W-1:0]        d;
	logic [ANGLE_BITS-1:0]        m;
	logic signed [ANGLE_BITS:0]   dw;
	logic [ANGLE_BITS:0]          ndw;
	logic [ANGLE_BITS-1:0]        mag_c;
	logic [TIMER_BITS:0]          dt_raw;
	logic [DT_W-1:0]              dt_ext;
	logic [DT_W-1:0]              mindt_eff;
	logic [DT_W-1:0]              dt_c;

	assign pf    = {turns_q, raw_q};
	assign pos_c = POS_W'(pf);
	assign d     = D_W'(pos_c) - D_W'(last_pos_q);
	assign m     = d[ANGLE_BITS-1:0];

	always_comb begin
		// wrap to a half turn; exactly plus or minus a half turn is kept
		if (d > HALF_D) begin
			dw = (m > HALF_M) ? {1'b1, m} : {1'b0, m};
		end else if (d < NHALF_D) begin
			dw = (m >= HALF_M) ? {1'b1, m} : {1'b0, m};
		end else begin
			dw = d[ANGLE_BITS:0];
		end
	end

	assign ndw   = -dw;
	assign mag_c = dw[ANGLE_BITS] ? ndw[ANGLE_BITS-1:0] : dw[ANGLE_BITS-1:0];

	// down-counter: equal values count as a wrap, giving TMASK
	assign dt_raw = (tim_q < last_timer_q) ? {1'b0, last_timer_q - tim_q}
		: {1'b0, TMASK - tim_q} + {1'b0, last_timer_q};
	assign dt_ext    = DT_W'(dt_raw);
	assign mindt_eff = (cfg_min_dt == '0) ? DT_W'(1) : DT_W'(cfg_min_dt);
	assign dt_c      = (dt_ext < mindt_eff) ? mindt_eff : dt_ext;

	// divider step
	logic [DT_W:0]  rem_sh;
	logic [DT_W:0]  rem_sub;
	logic           q_bit;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dt_q};
	assign q_bit   = rem_sh >= {1'b0, dt_q};
	assign sts.div_last = (cnt_q == CNT_LAST);

	// filter
	logic signed [R_W-1:0]   r_c;
	logic [GAIN_W-1:0]       g_c;
	logic signed [S_W-1:0]   sum_c;
	logic signed [S_W-1:0]   vv_c;
	logic signed [VEL_W-1:0] vsat_c;

	assign r_c  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	assign g_c  = (cfg_gain > GAIN_ONE) ? GAIN_ONE : cfg_gain;
	assign sum_c = acc_q + (S_W'(phi_q) <<< LO_W);
	assign vv_c  = sum_c >>> 16;

	always_comb begin
		if (vv_c > VMAX_S) begin
			vsat_c = VEL_MAX;
		end else if (vv_c < VMIN_S) begin
			vsat_c = VEL_MIN;
		end else begin
			vsat_c = vv_c[VEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q   <= '0;
			turns_q      <= '0;
			last_timer_q <= '0;
			last_pos_q   <= '0;
			vel_q        <= '0;
		end else begin
			if (cmd.turn) begin
				turns_q    <= turns_nxt;
				last_raw_q <= raw_q;
			end
			if (cmd.diff) begin
				last_pos_q   <= pos_c;
				last_timer_q <= tim_q;
			end
			if (cmd.fin) begin
				vel_q <= vnew_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= raw_angle;
			tim_q <= timer_value;
		end
		if (cmd.diff) begin
			pos_q <= pos_c;
			mag_q <= mag_c;
			neg_q <= dw[ANGLE_BITS];
			dt_q  <= dt_c;
		end
		if (cmd.mul) begin
			num_q <= {PROD_W'(mag_q) * PROD_W'(cfg_rate), 8'd0};
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			// one quotient bit per cycle, shifted in behind the dividend
			rem_q <= q_bit ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
			num_q <= {num_q[NUM_W-2:0], q_bit};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.fdel) begin
			delta_q <= DL_W'(r_c) - DL_W'(vel_q);
			acc_q   <= (S_W'(vel_q) <<< 16) + ROUND_S;
		end
		if (cmd.flo) begin
			plo_q <= PLO_W'(g_c) * PLO_W'(delta_q[LO_W-1:0]);
		end
		if (cmd.fhi) begin
			phi_q <= PHI_W'($signed({1'b0, g_c})) * PHI_W'($signed(delta_q[DL_W-1:LO_W]));
			acc_q <= acc_q + $signed(S_W'(plo_q));
		end
		if (cmd.fsum) begin
			vnew_q <= vsat_c;
		end
		if (cmd.fin) begin
			turn_count        <= turns_q;
			position          <= pos_q;
			velocity_filtered <= vnew_q;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/encoder_multiturn_velocity.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity
// Multi-turn unwrap and filtered velocity estimate for an absolute encoder.
// ----------------------------------------------------------------------------
// One sample at a time: a sample is taken when the block is idle and its
// result is loaded into the output register after the turn, difference,
// multiply, divide and filter steps; the block then returns to idle to take
// the next sample. The restoring divider, which retires one quotient bit per
// cycle over the ANGLE_BITS + 34 bit dividend, is the longest step. A new
// sample may be taken while the previous result still waits in the output
// register; a result that is not taken holds the sequencer in its last step.
module encoder_multiturn_velocity #(
	parameter int ANGLE_BITS = 12,
	parameter int TIMER_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [emv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [emv_pkg::CFG_DATA_W-1:0] cfg_wdata,
	emv_in_if.sink                            sample,
	emv_out_if.source                         result
);
	import emv_pkg::*;

	logic [THR_W-1:0]   threshold_q;
	logic [RATE_W-1:0]  rate_q;
	logic [MINDT_W-1:0] min_dt_q;
	logic [GAIN_W-1:0]  gain_q;

	emv_cmd_t cmd;
	emv_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			rate_q      <= RATE_RST;
			min_dt_q    <= MIN_DT_RST;
			gain_q      <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_wdata[THR_W-1:0];
				CFG_RATE:      rate_q      <= cfg_wdata[RATE_W-1:0];
				CFG_MIN_DT:    min_dt_q    <= cfg_wdata[MINDT_W-1:0];
				CFG_GAIN:      gain_q      <= cfg_wdata[GAIN_W-1:0];
				default:       threshold_q <= threshold_q;
			endcase
		end
	end

	emv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	emv_dp #(
		.ANGLE_BITS (ANGLE_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.raw_angle         (sample.raw_angle),
		.timer_value       (sample.timer_value),
		.cfg_threshold     (threshold_q),
		.cfg_rate          (rate_q),
		.cfg_min_dt        (min_dt_q),
		.cfg_gain          (gain_q),
		.turn_count        (result.turn_count),
		.position          (result.position),
		.velocity_filtered (result.velocity_filtered)
	);

endmodule
`default_nettype wire

/* tb/encoder_multiturn_velocity_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity_checker
// Watches the register port and both channels of the multi-turn encoder block.
// Keeps its own turn counter, position, timer and velocity filter state, works
// out the result of each accepted sample and compares the results in order.
// ----------------------------------------------------------------------------
module encoder_multiturn_velocity_checker
	import emv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	emv_in_if                     sample,
	emv_out_if                    result,
	output int                    errors,
	output int                    pending,
	output int                    checked
);

	localparam int     ANGLE_W = 12;
	localparam int     TIMER_W = 24;
	localparam longint FULL    = 64'sd1 <<< ANGLE_W;
	localparam longint HALF    = FULL / 2;

	typedef struct packed {
		logic signed [TURN_W-1:0] turn_count;
		logic signed [POS_W-1:0]  position;
		logic signed [VEL_W-1:0]  velocity;
	} motion_t;

	motion_t motion_q[$];

	// register copies
	logic [THR_W-1:0]   thr;
	logic [RATE_W-1:0]  rate;
	logic [MINDT_W-1:0] min_dt;
	logic [GAIN_W-1:0]  gain;

	// tracked state
	logic [ANGLE_W-1:0]       prev_angle;
	logic [TURN_W-1:0]        turns;
	logic [TIMER_W-1:0]       last_tim;
	logic signed [POS_W-1:0]  last_pos;
	logic signed [VEL_W-1:0]  vel_state;

	task automatic report(input string msg);
		if (errors < 40)
			$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic motion_t predict_motion(input logic [ANGLE_W-1:0] angle,
		input logic [TIMER_W-1:0] tim);
		longint      jump, tc, p, dt, mindt, d, m, r, g, acc, v;
		logic [63:0] mag, quot, u;
		motion_t     res;

		jump = longint'(angle) - longint'(prev_angle);
		if ((jump < 0 ? -jump : jump) > longint'(thr))
			turns = (jump > 0) ? turns - 1 : turns + 1;
		tc = longint'(signed'(turns));
		p = tc * FULL + longint'(angle);
		res.turn_count = turns;
		res.position = p[POS_W-1:0];

		// down-counter: a non-decreasing value means the counter wrapped
		if (tim < last_tim)
			dt = longint'(last_tim - tim);
		else
			dt = longint'(24'hFFFFFF) - longint'(tim) + longint'(last_tim);
		mindt = (min_dt == '0) ? 1 : longint'(min_dt);
		if (dt < mindt)
			dt = mindt;

		// fold the step into one half turn either way; exactly half stays
		d = longint'(res.position) - longint'(last_pos);
		if (d > HALF) begin
			m = d & (FULL - 1);
			d = (m > HALF) ? m - FULL : m;
		end else if (d < -HALF) begin
			m = d & (FULL - 1);
			d = (m >= HALF) ? m - FULL : m;
		end

		mag = (d < 0) ? -d : d;
		quot = (mag * 64'(rate) * 64'd256) / 64'(dt);
		r = (d < 0) ? -longint'(quot) : longint'(quot);

		g = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
		acc = (64'sd65536 - g) * longint'(vel_state) + g * r;
		// bias to unsigned so the shift rounds half up for either sign
		u = acc + 64'h8000_0000_0000_8000;
		v = longint'(u >> 16) - (64'sd1 <<< 47);
		if (v > longint'(VEL_MAX))
			v = longint'(VEL_MAX);
		else if (v < longint'(VEL_MIN))
			v = longint'(VEL_MIN);
		res.velocity = v[VEL_W-1:0];

		vel_state = v[VEL_W-1:0];
		prev_angle = angle;
		last_tim = tim;
		last_pos = res.position;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		motion_t want;
		if (!arst_n) begin
			thr = THRESHOLD_RST;
			rate = RATE_RST;
			min_dt = MIN_DT_RST;
			gain = GAIN_RST;
			prev_angle = '0;
			turns = '0;
			last_tim = '0;
			last_pos = '0;
			vel_state = '0;
			motion_q.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_THRESHOLD: thr = cfg_wdata[THR_W-1:0];
					CFG_RATE:      rate = cfg_wdata[RATE_W-1:0];
					CFG_MIN_DT:    min_dt = cfg_wdata[MINDT_W-1:0];
					CFG_GAIN:      gain = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (motion_q.size() == 0) begin
					report($sformatf("result with nothing pending: turns %0d pos %0d vel %0d",
						result.turn_count, result.position, result.velocity_filtered));
				end else begin
					want = motion_q.pop_front();
					checked++;
					if (result.turn_count !== want.turn_count)
						report($sformatf("turn_count %0d, want %0d",
							result.turn_count, want.turn_count));
					if (result.position !== want.position)
						report($sformatf("position %0d, want %0d",
							result.position, want.position));
					if (result.velocity_filtered !== want.velocity)
						report($sformatf("velocity_filtered %0d, want %0d",
							result.velocity_filtered, want.velocity));
				end
			end
			if (sample.valid && sample.ready)
				motion_q.push_back(predict_motion(sample.raw_angle, sample.timer_value));
			pending = motion_q.size();
		end
	end

endmodule

/* tb/encoder_multiturn_velocity_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_multiturn_velocity_tb
// Feeds angle and timer samples to the multi-turn encoder block under a range
// of register settings, with random stalls on both channels, and lets the
// checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module encoder_multiturn_velocity_tb;
	import emv_pkg::*;

	localparam int ANGLE_BITS = 12;
	localparam int TIMER_BITS = 24;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  sample_fire = 1'b0;

	int fail_count;
	int outstanding;
	int results_checked;
	int send_idle_pct = 23;
	int recv_idle_pct = 79;
	int samples_sent = 0;
	int settings_used = 1;
	int speed = 37;
	int tick_step = 900;
	logic [ANGLE_BITS-1:0] cur_angle = '0;
	logic [TIMER_BITS-1:0] cur_timer = '0;

	emv_in_if #(.ANGLE_BITS(ANGLE_BITS), .TIMER_BITS(TIMER_BITS)) sample_ch ();
	emv_out_if result_ch ();

	encoder_multiturn_velocity #(
		.ANGLE_BITS(ANGLE_BITS),
		.TIMER_BITS(TIMER_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	encoder_multiturn_velocity_checker motion_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch),
		.errors    (fail_count),
		.pending   (outstanding),
		.checked   (results_checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		sample_fire <= sample_ch.valid & sample_ch.ready;
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still pending", outstanding);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_sample(input logic [ANGLE_BITS-1:0] angle,
		input logic [TIMER_BITS-1:0] tim);
		if (samples_sent < 480) begin
			send_idle_pct = 23;
			recv_idle_pct = 79;
		end else if (samples_sent < 960) begin
			send_idle_pct = 79;
			recv_idle_pct = 23;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_angle <= angle;
		sample_ch.timer_value <= tim;
		do @(negedge clk); while (!sample_fire);
		samples_sent++;
		cur_angle = angle;
		cur_timer = tim;
	endtask

	// drop valid, drain, then rewrite all four registers back to back
	task automatic load_settings(input logic [THR_W-1:0] thr, input logic [RATE_W-1:0] rate,
		input logic [MINDT_W-1:0] mindt, input logic [GAIN_W-1:0] gain);
		sample_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_wdata <= CFG_DATA_W'(thr);
		@(negedge clk);
		cfg_index <= CFG_RATE;
		cfg_wdata <= CFG_DATA_W'(rate);
		@(negedge clk);
		cfg_index <= CFG_MIN_DT;
		cfg_wdata <= CFG_DATA_W'(mindt);
		@(negedge clk);
		cfg_index <= CFG_GAIN;
		cfg_wdata <= CFG_DATA_W'(gain);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// mostly a shaft turning at a held speed and tick step, with some noise
	task automatic random_burst(input int count);
		int sel;
		logic [ANGLE_BITS-1:0] a;
		logic [TIMER_BITS-1:0] t;
		repeat (count) begin
			if ($urandom_range(0, 15) == 0)
				speed = int'($urandom_range(0, 4400)) - 2200;
			if ($urandom_range(0, 15) == 0)
				tick_step = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 24'hFFFFFF))
					: int'($urandom_range(1, 20000));
			sel = $urandom_range(0, 19);
			a = cur_angle;
			t = cur_timer;
			if (sel == 0) begin
				a = ANGLE_BITS'($urandom);
				t = TIMER_BITS'($urandom);
			end else if (sel == 1) begin
				// jitter in place, timer held
				a = a + ANGLE_BITS'($urandom_range(0, 10)) - ANGLE_BITS'(5);
			end else begin
				a = a + ANGLE_BITS'(speed);
				t = t - TIMER_BITS'(tick_step);
			end
			send_sample(a, t);
		end
	endtask

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.raw_angle = '0;
		sample_ch.timer_value = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: timer equal to reset value, turn edges, half-turn folds
		send_sample(12'd0,    24'h000000);
		send_sample(12'd4095, 24'hFFFFFF);
		send_sample(12'd0,    24'hFFFFF0);
		send_sample(12'd0,    24'hFFFFF0);
		send_sample(12'd2048, 24'hFFFFEF);
		send_sample(12'd0,    24'hFFF000);
		send_sample(12'd3276, 24'hFF0000);
		send_sample(12'd0,    24'hFE0000);
		send_sample(12'd3277, 24'hFD0000);
		send_sample(12'd0,    24'hFC0000);
		send_sample(12'd2100, 24'h000010);
		send_sample(12'd100,  24'hFFFF00);
		send_sample(12'd4095, 24'hFFFE00);
		send_sample(12'd1,    24'h000001);
		send_sample(12'd4094, 24'h000000);
		send_sample(12'hAAA,  24'hAAAAAA);
		send_sample(12'h555,  24'h555555);
		random_burst(205);

		load_settings(12'd4095, 26'd50_000_000, 24'd1, GAIN_ONE);
		random_burst(205);
		// zero rate, zero minimum, frozen filter
		load_settings('0, '0, '0, '0);
		random_burst(205);
		// widest rate and clamp, oversized gain
		load_settings(12'd2047, '1, '1, '1);
		random_burst(205);
		load_settings(12'd1, 26'd1, 24'd1000, 17'd1);
		random_burst(205);
		repeat (2) begin
			load_settings(THR_W'($urandom_range(0, 4095)),
				RATE_W'($urandom_range(1, 50_000_000)),
				MINDT_W'($urandom_range(1, 65535)),
				GAIN_W'($urandom_range(0, 65536)));
			random_burst(205);
		end

		sample_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (64) @(negedge clk);

		$display("Sent %0d samples across %0d register settings", samples_sent, settings_used);
		$display("Checked %0d results, %0d mismatches", results_checked, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
